// ===== rtl/core/first_fit_frame_search_top_assert.svh =====
// Assertion macros for the first fit frame search block.
// Each macro samples on clk and is disabled while rst is high.
`ifndef FIRST_FIT_FRAME_SEARCH_TOP_ASSERT_SVH
`define FIRST_FIT_FRAME_SEARCH_TOP_ASSERT_SVH

// Same-cycle implication.
`define FFS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ffs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ffs_pkg;

  localparam int MAX_REGIONS = 3;
  localparam int REGIONS_DEF = 3;

  localparam int PAGE_BITS  = 12;
  localparam int FC_W       = 21;
  localparam int REG_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int S_TDATA_W  = 160;
  localparam int M_TDATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RES_FIRST   = 3'd1;

  localparam logic [31:0] ENTRY_TYPE_RAM = 32'd1;
  localparam logic [FC_W-1:0] FRAME_COUNT_RESET = 21'd1;

  localparam logic [31:0] RES_LOW_RESET  [MAX_REGIONS] = '{32'h0, 32'h0, 32'h000B8000};
  localparam logic [31:0] RES_HIGH_RESET [MAX_REGIONS] = '{32'h0, 32'h0, 32'h000B8F9F};

  typedef struct packed {
    logic        fit;
    logic [31:0] start;
  } fit_t;

endpackage

`default_nettype wire

// ===== rtl/core/first_fit_frame_search_top.sv =====
// First fit frame search.
// s_* channel: one memory map entry per item. s_tdata holds base, length
// and type; s_tlast marks the final entry of the map.
// m_* channel: one result item per map, sent after the entry with s_tlast.
// m_tuser is the found flag, m_tdata the page-aligned start (0 if none).
// cfg_we / cfg_index / cfg_data write the frame count and the reserved
// region bounds; write them only while the block is idle.
// Throughput: one entry per cycle while no last entry waits for a pending
// result. Each entry is evaluated combinationally between the input
// register and the search state. The last entry passes through the input
// register and then the result register, which drives m_tvalid.
// When m_tready is low the result register holds its item; entries that
// are not last keep flowing, and a last entry waits in the input register,
// holding s_tready low, until the pending result is taken.
// Reset (rst, synchronous) empties both registers, clears the search state
// and loads the default frame count and reserved regions.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_frame_search_top
  import ffs_pkg::*;
#(
  parameter int REGIONS = REGIONS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,   // entry_base, entry_length, entry_type
  input  wire logic                 s_tlast,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [M_TDATA_W-1:0]      m_tdata,   // start_address
  output logic                      m_tuser,   // found
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [REG_W-1:0]     cfg_data
);

  `include "first_fit_frame_search_top_assert.svh"

  logic [FC_W-1:0]          frame_count;
  logic [REGIONS-1:0][31:0] res_low;
  logic [REGIONS-1:0][31:0] res_high;

  logic        in_valid;
  logic [63:0] in_base;
  logic [63:0] in_length;
  logic [31:0] in_type;
  logic        in_last;

  logic        have_fit;
  logic [31:0] fit_start;
  logic        out_valid;
  logic        out_found;
  logic [31:0] out_start;

  fit_t        eval_res;
  logic        advance;
  logic        take;
  logic        new_fit;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= FRAME_COUNT_RESET;
      for (int i = 0; i < REGIONS; i++) begin
        res_low[i]  <= RES_LOW_RESET[i];
        res_high[i] <= RES_HIGH_RESET[i];
      end
    end else if (cfg_we) begin
      if (cfg_index == CFG_FRAME_COUNT) begin
        frame_count <= cfg_data[FC_W-1:0];
      end
      for (int i = 0; i < REGIONS; i++) begin
        if (cfg_index == CFG_IDX_W'(CFG_RES_FIRST + 2 * i)) begin
          res_low[i] <= cfg_data;
        end
        if (cfg_index == CFG_IDX_W'(CFG_RES_FIRST + 2 * i + 1)) begin
          res_high[i] <= cfg_data;
        end
      end
    end
  end

  ffs_entry_eval #(.REGIONS(REGIONS)) u_eval (
    .entry_base   (in_base),
    .entry_length (in_length),
    .entry_type   (in_type),
    .frame_count  (frame_count),
    .res_low      (res_low),
    .res_high     (res_high),
    .result       (eval_res)
  );

  always_comb begin
    advance  = in_valid && (!in_last || !out_valid || m_tready);
    s_tready = !in_valid || advance;
    take     = s_tvalid && s_tready;
    new_fit  = !have_fit && eval_res.fit;
    m_tvalid = out_valid;
    m_tuser  = out_found;
    m_tdata  = out_start;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_base   <= s_tdata[63:0];
      in_length <= s_tdata[127:64];
      in_type   <= s_tdata[159:128];
      in_last   <= s_tlast;
    end
    if (advance && in_last) begin
      out_found <= have_fit || eval_res.fit;
      out_start <= have_fit ? fit_start : (eval_res.fit ? eval_res.start : 32'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      have_fit  <= 1'b0;
      fit_start <= 32'd0;
    end else begin
      if (take) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance && in_last) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        if (in_last) begin
          have_fit  <= 1'b0;
          fit_start <= 32'd0;
        end else if (new_fit) begin
          have_fit  <= 1'b1;
          fit_start <= eval_res.start;
        end
      end
    end
  end

  `FFS_ASSERT_NOW(a_nofit_zero, m_tvalid && !m_tuser, m_tdata == 32'd0, "no fit with nonzero start")
  `FFS_ASSERT_NOW(a_fit_aligned, m_tvalid && m_tuser, m_tdata[PAGE_BITS-1:0] == '0, "misaligned")
  `FFS_ASSERT_NEXT(a_clear_on_last, advance && in_last, !have_fit && fit_start == '0, "not cleared")
  `FFS_ASSERT_NOW(a_idle_state, !have_fit, fit_start == 32'd0, "stale fit start")

endmodule

`default_nettype wire

// ===== rtl/core/ffs_overlap.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ffs_overlap
  import ffs_pkg::*;
#(
  parameter int REGIONS = REGIONS_DEF
) (
  input  wire logic [63:0]               piece_base,
  input  wire logic [63:0]               piece_end,
  input  wire logic                      piece_nonempty,
  input  wire logic [REGIONS-1:0][31:0]  res_low,
  input  wire logic [REGIONS-1:0][31:0]  res_high,
  output logic      [REGIONS-1:0]        hit
);

  logic [63:0] rs;
  logic [63:0] re;

  always_comb begin
    rs = '0;
    re = '0;
    for (int i = 0; i < REGIONS; i++) begin
      rs = {32'd0, res_low[i]};
      re = {32'd0, res_high[i]};
      hit[i] = piece_nonempty &&
               !(((piece_base < rs) && (piece_end < rs)) ||
                 ((re < piece_base) && (re < piece_end)));
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ffs_piece_fit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ffs_piece_fit
  import ffs_pkg::*;
(
  input  wire logic [32:0]     piece_base,
  input  wire logic [63:0]     piece_len,
  input  wire logic [FC_W-1:0] frame_count,
  output fit_t                 result
);

  logic [33:0] aligned;
  logic [33:0] pad_w;
  logic [63:0] pad;
  logic [63:0] rest;
  logic [63:0] need;
  logic [31:0] room;

  always_comb begin
    aligned = ({1'b0, piece_base} + 34'h0FFF) & ~34'h0FFF;
    pad_w   = aligned - {1'b0, piece_base};
    pad     = {51'd0, pad_w[PAGE_BITS:0]};
    rest    = piece_len - pad;
    need    = {31'd0, frame_count, {PAGE_BITS{1'b0}}};
    room    = 32'hFFFF_FFFF - aligned[31:0];
    result.start = aligned[31:0];
    result.fit   = !piece_base[32] &&
                   (pad <= piece_len) &&
                   (rest >= need) &&
                   (aligned[33:32] == 2'b00) &&
                   (rest <= {32'd0, room});
  end

endmodule

`default_nettype wire

// ===== rtl/core/ffs_entry_eval.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ffs_entry_eval
  import ffs_pkg::*;
#(
  parameter int REGIONS = REGIONS_DEF
) (
  input  wire logic [63:0]              entry_base,
  input  wire logic [63:0]              entry_length,
  input  wire logic [31:0]              entry_type,
  input  wire logic [FC_W-1:0]          frame_count,
  input  wire logic [REGIONS-1:0][31:0] res_low,
  input  wire logic [REGIONS-1:0][31:0] res_high,
  output fit_t                          result
);

  logic [64:0]        sum;
  logic [63:0]        entry_tail;
  logic [63:0]        base_lo;
  logic [REGIONS-1:0] ov_entry;
  logic [REGIONS-1:0] ov_h1;
  logic [REGIONS-1:0] ov_h2;
  logic [31:0]        rs;
  logic [31:0]        re;
  logic               base_ok;
  logic               len_ok;
  logic [31:0]        h1_len;
  logic [63:0]        h1_end;
  logic               h1_cond;
  logic [32:0]        h2_base;
  logic [63:0]        h2_len;
  logic               h2_cond;
  fit_t               plain_res;
  fit_t               h1_res;
  fit_t               h2_res;
  logic               h1_ok;
  logic               h2_ok;

  always_comb begin
    sum        = {1'b0, entry_base} + {1'b0, entry_length};
    entry_tail = sum[64] ? {64{1'b1}} : (sum[63:0] - 64'd1);
    base_lo    = {32'd0, entry_base[31:0]};
    base_ok    = (entry_base[63:32] == 32'd0);
    len_ok     = (entry_type == ENTRY_TYPE_RAM) &&
                 (entry_length >= {31'd0, frame_count, {PAGE_BITS{1'b0}}});
  end

  always_comb begin
    rs = '0;
    re = '0;
    for (int i = REGIONS - 1; i >= 0; i--) begin
      if (ov_entry[i]) begin
        rs = res_low[i];
        re = res_high[i];
      end
    end
    h1_cond = (entry_base[31:0] <= rs);
    h1_len  = rs - entry_base[31:0];
    h1_end  = {32'd0, rs - 32'd1};
    h2_cond = ({32'd0, re} <= entry_tail);
    h2_base = {1'b0, re} + 33'd1;
    h2_len  = entry_tail - {32'd0, re};
  end

  ffs_overlap #(.REGIONS(REGIONS)) u_ov_entry (
    .piece_base     (base_lo),
    .piece_end      (entry_tail),
    .piece_nonempty (entry_length != 64'd0),
    .res_low        (res_low),
    .res_high       (res_high),
    .hit            (ov_entry)
  );

  ffs_overlap #(.REGIONS(REGIONS)) u_ov_h1 (
    .piece_base     (base_lo),
    .piece_end      (h1_end),
    .piece_nonempty (h1_len != 32'd0),
    .res_low        (res_low),
    .res_high       (res_high),
    .hit            (ov_h1)
  );

  ffs_overlap #(.REGIONS(REGIONS)) u_ov_h2 (
    .piece_base     ({31'd0, h2_base}),
    .piece_end      (entry_tail),
    .piece_nonempty (h2_len != 64'd0),
    .res_low        (res_low),
    .res_high       (res_high),
    .hit            (ov_h2)
  );

  ffs_piece_fit u_fit_plain (
    .piece_base  ({1'b0, entry_base[31:0]}),
    .piece_len   (entry_length),
    .frame_count (frame_count),
    .result      (plain_res)
  );

  ffs_piece_fit u_fit_h1 (
    .piece_base  ({1'b0, entry_base[31:0]}),
    .piece_len   ({32'd0, h1_len}),
    .frame_count (frame_count),
    .result      (h1_res)
  );

  ffs_piece_fit u_fit_h2 (
    .piece_base  (h2_base),
    .piece_len   (h2_len),
    .frame_count (frame_count),
    .result      (h2_res)
  );

  always_comb begin
    h1_ok = h1_cond && (ov_h1 == '0) && h1_res.fit;
    h2_ok = h2_cond && (ov_h2 == '0) && h2_res.fit;
    if (ov_entry == '0) begin
      result.fit   = base_ok && len_ok && plain_res.fit;
      result.start = plain_res.start;
    end else begin
      result.fit   = base_ok && len_ok && (h1_ok || h2_ok);
      result.start = h1_ok ? h1_res.start : h2_res.start;
    end
  end

endmodule

`default_nettype wire
